// ----- rtl/hcb_pkg.sv -----
// ----------------------------------------------------------------------------
// Huffman code builder package
// Field widths and the control record shared by the builder and its scanner.
// ----------------------------------------------------------------------------
package hcb_pkg;

   localparam int SYMBOL_W    = 16;
   localparam int IN_WEIGHT_W = 24;
   localparam int WEIGHT_W    = 31;
   localparam int CODE_W      = 63;
   localparam int LENGTH_W    = 6;

   // Control of the two-minimum scanner for one cycle.
   typedef struct packed {
      logic clear;   // forget both candidates before a new pass
      logic take;    // present an active node for comparison
   } scan_ctl_type;

endpackage

// ----- rtl/hcb_pair_scan.sv -----
// ----------------------------------------------------------------------------
// Two-minimum scanner
// Tracks the lightest and second lightest node over one pass in index order.
// ----------------------------------------------------------------------------
module hcb_pair_scan
   import hcb_pkg::*;
#(
   parameter int IDX_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  scan_ctl_type        ctl,
   input  logic [IDX_W-1:0]    node_idx,
   input  logic [WEIGHT_W-1:0] node_weight,
   output logic [IDX_W-1:0]    first_idx,
   output logic [WEIGHT_W-1:0] first_weight,
   output logic [IDX_W-1:0]    second_idx,
   output logic [WEIGHT_W-1:0] second_weight
);

   logic                first_found_ff, first_found_in;
   logic                second_found_ff, second_found_in;
   logic [IDX_W-1:0]    first_idx_ff, first_idx_in, second_idx_ff, second_idx_in;
   logic [WEIGHT_W-1:0] first_w_ff, first_w_in, second_w_ff, second_w_in;

   // Strict compares keep the earlier index on equal weights.
   always_comb begin
      first_found_in  = first_found_ff;
      second_found_in = second_found_ff;
      first_idx_in    = first_idx_ff;
      first_w_in      = first_w_ff;
      second_idx_in   = second_idx_ff;
      second_w_in     = second_w_ff;
      if (ctl.clear) begin
         first_found_in  = 1'b0;
         second_found_in = 1'b0;
      end else if (ctl.take) begin
         if (!first_found_ff || (node_weight < first_w_ff)) begin
            second_found_in = first_found_ff;
            second_idx_in   = first_idx_ff;
            second_w_in     = first_w_ff;
            first_found_in  = 1'b1;
            first_idx_in    = node_idx;
            first_w_in      = node_weight;
         end else if (!second_found_ff || (node_weight < second_w_ff)) begin
            second_found_in = 1'b1;
            second_idx_in   = node_idx;
            second_w_in     = node_weight;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_found_ff  <= 1'b0;
         second_found_ff <= 1'b0;
      end else begin
         first_found_ff  <= first_found_in;
         second_found_ff <= second_found_in;
      end
   end

   always_ff @(posedge clock) begin
      first_idx_ff  <= first_idx_in;
      first_w_ff    <= first_w_in;
      second_idx_ff <= second_idx_in;
      second_w_ff   <= second_w_in;
   end

   assign first_idx     = first_idx_ff;
   assign first_weight  = first_w_ff;
   assign second_idx    = second_idx_ff;
   assign second_weight = second_w_ff;

endmodule

// ----- rtl/huffman_code_builder.sv -----
// ----------------------------------------------------------------------------
// Huffman code builder
// Loads weighted symbols, builds the code tree in node memories, emits codes.
// ----------------------------------------------------------------------------
// Symbols are loaded one transaction per cycle while the builder is loading;
// the transaction with tlast set is stored like the others and then starts
// construction (symbols beyond MAX_SYMBOLS are dropped, but tlast still starts
// the build). Each merge is one pass over every node created so far through
// the registered-read weight memory. Codes then leave in load order; each one
// is a walk up the parent memory, one code bit per step. The first tree bit
// sits in the most significant used bit, a lone symbol gets a zero-length
// code, and tlast on the result channel marks the final code. No new symbol is
// taken until the final code has been handed to the output register, which
// then waits for the consumer independently.
// ----------------------------------------------------------------------------
module huffman_code_builder
   import hcb_pkg::*;
#(
   parameter int MAX_SYMBOLS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // symbol [15:0], weight [39:16]
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // out_symbol [15:0], code_bits [78:16],
                                    // code_length [84:79], zero fill [87:85]
   output logic        rsp_tlast    // end_of_codes
);

   localparam int NODE_CAP = 2 * MAX_SYMBOLS - 1;
   localparam int IDX_W    = $clog2(NODE_CAP + 1);
   localparam int CNT_W    = $clog2(MAX_SYMBOLS + 1);
   localparam int SIDX_W   = $clog2(MAX_SYMBOLS);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_MERGE  = 3'd2;
   localparam logic [2:0] ST_LINK   = 3'd3;
   localparam logic [2:0] ST_START  = 3'd4;
   localparam logic [2:0] ST_CHECK  = 3'd5;
   localparam logic [2:0] ST_STEP   = 3'd6;
   localparam logic [2:0] ST_EMIT   = 3'd7;

   // Storage: symbols, node weights and a link word of parent index and side.
   logic [SYMBOL_W-1:0] symbol_mem [MAX_SYMBOLS];
   logic [WEIGHT_W-1:0] weight_mem [NODE_CAP];
   logic [IDX_W:0]      link_mem   [NODE_CAP];

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [NODE_CAP-1:0] active_ff, active_in;
   logic [IDX_W-1:0]    next_ff, next_in;
   logic [IDX_W-1:0]    root_ff, root_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic                pend_ff, pend_in;
   logic                pend_act_ff;
   logic [IDX_W-1:0]    pend_idx_ff;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [CODE_W-1:0]   code_ff, code_in, mask_ff, mask_in;
   logic [LENGTH_W-1:0] len_ff, len_in;
   logic                out_valid_ff, out_valid_in;
   logic [SYMBOL_W-1:0] out_sym_ff;
   logic [CODE_W-1:0]   out_code_ff;
   logic [LENGTH_W-1:0] out_len_ff;
   logic                out_last_ff;

   logic [SYMBOL_W-1:0] sym_rd_ff;
   logic [WEIGHT_W-1:0] weight_rd_ff;
   logic [IDX_W:0]      link_rd_ff;

   logic                load_fire, store_en, emit_fire;
   logic [CNT_W-1:0]    n_total;
   logic [IDX_W:0]      root_wide;
   logic [IDX_W-1:0]    first_idx, second_idx;
   logic [WEIGHT_W-1:0] first_w, second_w;
   scan_ctl_type        scan_ctl;
   logic                last_code;

   assign req_tready = (state_ff == ST_LOAD);
   assign load_fire  = req_tvalid && req_tready;
   assign store_en   = load_fire && (count_ff < CNT_W'(MAX_SYMBOLS));
   assign n_total    = count_ff + CNT_W'(store_en);
   assign root_wide  = {(IDX_W + 1 - CNT_W)'(0), n_total} + {(IDX_W + 1 - CNT_W)'(0), n_total}
                       - (IDX_W + 1)'(2);
   assign emit_fire  = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_tready);
   assign last_code  = (k_ff + CNT_W'(1)) == count_ff;

   assign scan_ctl.clear = (state_ff == ST_LINK) || load_fire;
   assign scan_ctl.take  = pend_ff && pend_act_ff;

   hcb_pair_scan #(
      .IDX_W(IDX_W)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .ctl          (scan_ctl),
      .node_idx     (pend_idx_ff),
      .node_weight  (weight_rd_ff),
      .first_idx    (first_idx),
      .first_weight (first_w),
      .second_idx   (second_idx),
      .second_weight(second_w)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      active_in    = active_ff;
      next_in      = next_ff;
      root_in      = root_ff;
      ptr_in       = ptr_ff;
      pend_in      = 1'b0;
      k_in         = k_ff;
      j_in         = j_ff;
      code_in      = code_ff;
      mask_in      = mask_ff;
      len_in       = len_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         ST_LOAD: begin
            if (load_fire) begin
               count_in = n_total;
               if (req_tlast) begin
                  for (int i = 0; i < NODE_CAP; i++) begin
                     active_in[i] = (i < int'(n_total));
                  end
                  next_in  = IDX_W'(n_total);
                  root_in  = root_wide[IDX_W-1:0];
                  ptr_in   = '0;
                  k_in     = '0;
                  // A lone symbol has nothing to merge.
                  state_in = (n_total == CNT_W'(1)) ? ST_START : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (ptr_ff != next_ff) begin
               pend_in = 1'b1;
               ptr_in  = ptr_ff + IDX_W'(1);
            end else if (!pend_ff) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            active_in[first_idx]  = 1'b0;
            active_in[second_idx] = 1'b0;
            active_in[next_ff]    = 1'b1;
            state_in              = ST_LINK;
         end
         ST_LINK: begin
            next_in  = next_ff + IDX_W'(1);
            ptr_in   = '0;
            state_in = (next_ff == root_ff) ? ST_START : ST_SCAN;
         end
         ST_START: begin
            j_in     = IDX_W'(k_ff);
            code_in  = '0;
            mask_in  = CODE_W'(1);
            len_in   = '0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = (j_ff == root_ff) ? ST_EMIT : ST_STEP;
         end
         ST_STEP: begin
            if (link_rd_ff[0]) begin
               code_in = code_ff | mask_ff;
            end
            mask_in  = mask_ff << 1;
            len_in   = len_ff + LENGTH_W'(1);
            j_in     = link_rd_ff[IDX_W:1];
            state_in = ST_CHECK;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               out_valid_in = 1'b1;
               if (last_code) begin
                  active_in = '0;
                  count_in  = '0;
                  state_in  = ST_LOAD;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = ST_START;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         active_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff     <= next_in;
      root_ff     <= root_in;
      ptr_ff      <= ptr_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      code_ff     <= code_in;
      mask_ff     <= mask_in;
      len_ff      <= len_in;
      pend_act_ff <= active_ff[ptr_ff];
      pend_idx_ff <= ptr_ff;
      if (emit_fire) begin
         out_sym_ff  <= sym_rd_ff;
         out_code_ff <= code_ff;
         out_len_ff  <= len_ff;
         out_last_ff <= last_code;
      end
   end

   // Symbol memory: written while loading, read at the start of each walk.
   always_ff @(posedge clock) begin
      if (store_en) begin
         symbol_mem[count_ff[SIDX_W-1:0]] <= req_tdata[15:0];
      end
      sym_rd_ff <= symbol_mem[k_ff[SIDX_W-1:0]];
   end

   // Weight memory: leaves written on load, merged nodes in the merge cycle.
   // A scan only reads nodes below the one being written, so no forwarding.
   always_ff @(posedge clock) begin
      if (store_en) begin
         weight_mem[IDX_W'(count_ff)] <= {(WEIGHT_W - IN_WEIGHT_W)'(0), req_tdata[39:16]};
      end else if (state_ff == ST_MERGE) begin
         weight_mem[next_ff] <= first_w + second_w;
      end
      weight_rd_ff <= weight_mem[ptr_ff];
   end

   // Link memory: left child recorded in the merge cycle, right child after.
   always_ff @(posedge clock) begin
      if (state_ff == ST_MERGE) begin
         link_mem[first_idx] <= {next_ff, 1'b0};
      end else if (state_ff == ST_LINK) begin
         link_mem[second_idx] <= {next_ff, 1'b1};
      end
      link_rd_ff <= link_mem[j_ff];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_len_ff, out_code_ff, out_sym_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- sim/tb_huffman_code_builder.sv -----
// ----------------------------------------------------------------------------
// Huffman code builder testbench
// Loads blocks of weighted symbols in streamed transactions, predicts every
// code with a behavioural tree builder and checks each result transaction
// against the oldest predicted code, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_huffman_code_builder;
   import hcb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SYM    = 64;
   localparam int NODE_MAX   = 2 * MAX_SYM - 1;
   localparam int CYCLE_STOP = 3000000;

   // One predicted code, as it should appear on the result channel.
   typedef struct {
      logic [SYMBOL_W-1:0] symbol;
      logic [CODE_W-1:0]   bits;
      logic [LENGTH_W-1:0] length;
      logic                final_code;
   } code_rec_type;

   // One row of the directed stimulus; check_len is -1 where only the
   // predictor decides the result.
   typedef struct {
      logic [SYMBOL_W-1:0]    symbol;
      logic [IN_WEIGHT_W-1:0] weight;
      logic                   last;
      int                     check_len;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // symbol [15:0], weight [39:16]
   logic        req_tlast;    // last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;    // out_symbol [15:0], code_bits [78:16],
                              // code_length [84:79], zero fill [87:85]
   logic        rsp_tlast;    // end_of_codes

   // Predictor state, kept in step with every accepted transaction.
   logic [SYMBOL_W-1:0] sym_held [MAX_SYM];
   logic [WEIGHT_W-1:0] wt_of    [NODE_MAX];
   int                  parent_of[NODE_MAX];
   bit                  side_of  [NODE_MAX];
   bit                  live     [NODE_MAX];
   int                  held_count;

   code_rec_type expected_codes[$];
   int           fixed_lengths[$];   // directed length checks, -1 for none
   int           fail_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct;
   int           recv_idle_pct;
   bit           recv_hold;

   huffman_code_builder #(.MAX_SYMBOLS(MAX_SYM)) uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Removes and returns the lightest live node below the limit; the lowest
   // index wins on equal weight, which is also the earliest created node.
   function automatic int take_lightest(int limit);
      int best;
      best = -1;
      for (int i = 0; i < limit; i++)
         if (live[i] && (best < 0 || wt_of[i] < wt_of[best]))
            best = i;
      live[best] = 1'b0;
      return best;
   endfunction

   // Builds the tree over the held symbols and queues one code per symbol.
   task automatic build_codes(int check_len);
      int           n, next, root, a, b, j;
      code_rec_type rec;
      n = held_count;
      next = n;
      for (int k = 0; k < n; k++)
         live[k] = 1'b1;
      while (next < 2 * n - 1) begin
         a = take_lightest(next);
         b = take_lightest(next);
         wt_of[next] = wt_of[a] + wt_of[b];
         parent_of[a] = next;
         side_of[a]   = 1'b0;
         parent_of[b] = next;
         side_of[b]   = 1'b1;
         live[next]   = 1'b1;
         next++;
      end
      root = next - 1;
      for (int k = 0; k < n; k++) begin
         rec.bits   = '0;
         rec.length = '0;
         j = k;
         // Walking up from the leaf yields the bit nearest the leaf first,
         // so it lands in the LSB and the root bit ends up in the highest used bit.
         while (j != root) begin
            rec.bits[rec.length] = side_of[j];
            rec.length++;
            j = parent_of[j];
         end
         rec.symbol     = sym_held[k];
         rec.final_code = (k == n - 1);
         expected_codes.insert(expected_codes.size(), rec);
         fixed_lengths.insert(fixed_lengths.size(), check_len);
      end
      for (int i = 0; i < NODE_MAX; i++)
         live[i] = 1'b0;
      held_count = 0;
   endtask

   // Mirrors one accepted load transaction into the predictor.
   task automatic predict_load(logic [SYMBOL_W-1:0] sym, logic [IN_WEIGHT_W-1:0] wt,
                               logic last, int check_len);
      if (held_count < MAX_SYM) begin
         sym_held[held_count] = sym;
         wt_of[held_count]    = WEIGHT_W'(wt);
         held_count++;
      end
      if (last)
         build_codes(check_len);
   endtask

   // Offers one transaction and waits for it to be accepted; random idle
   // cycles go in front of it at the current sender rate.
   task automatic send_symbol(logic [SYMBOL_W-1:0] sym, logic [IN_WEIGHT_W-1:0] wt,
                              logic last, int check_len = -1);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wt, sym};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_load(sym, wt, last, check_len);
   endtask

   // Waits until every predicted code has come back; no load ever leaves a
   // build running here, since every block ends with a last transaction
   // before this is called.
   task automatic drain_codes();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_codes.size() != 0)
         @(posedge clock);
   endtask

   // Sends one block of n random symbols; one weight mode is picked per block.
   task automatic send_random_block(int n);
      logic [IN_WEIGHT_W-1:0] wt;
      int                     mode;
      mode = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
         case (mode)
            0: wt = IN_WEIGHT_W'($urandom_range(3));       // many ties
            1: wt = IN_WEIGHT_W'(1) << $urandom_range(23); // skewed, deep trees
            2: wt = IN_WEIGHT_W'($urandom);
            default: wt = IN_WEIGHT_W'($urandom_range(50));
         endcase
         send_symbol(SYMBOL_W'($urandom), wt, i == n - 1);
      end
   endtask

   // Receiver: random back-pressure, suspended entirely while held off.
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Every result transaction is compared with the oldest predicted code.
   always @(posedge clock) begin
      code_rec_type want;
      int           want_len;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_codes.size() == 0) begin
            $error("unexpected result transaction: %h", rsp_tdata);
            fail_count++;
         end else begin
            want     = expected_codes.pop_front();
            want_len = fixed_lengths.pop_front();
            if (rsp_tdata[15:0] !== want.symbol) begin
               $error("out_symbol: expected %h, got %h", want.symbol, rsp_tdata[15:0]);
               fail_count++;
            end
            if (rsp_tdata[78:16] !== want.bits) begin
               $error("code_bits: expected %h, got %h", want.bits, rsp_tdata[78:16]);
               fail_count++;
            end
            if (rsp_tdata[84:79] !== want.length) begin
               $error("code_length: expected %0d, got %0d", want.length,
                      rsp_tdata[84:79]);
               fail_count++;
            end
            if (want_len >= 0 && rsp_tdata[84:79] !== LENGTH_W'(want_len)) begin
               $error("code_length: expected %0d, got %0d", want_len, rsp_tdata[84:79]);
               fail_count++;
            end
            if (rsp_tlast !== want.final_code) begin
               $error("end_of_codes: expected %b, got %b", want.final_code, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_STOP) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Directed table: lone symbols (zero length), zero weights, extreme values,
   // ties, repeated symbols and a two-symbol tree with known one-bit codes.
   stim_row_type directed [20] = '{
      '{16'h0000, 24'h000000, 1'b1, 0},
      '{16'hFFFF, 24'hFFFFFF, 1'b1, 0},
      '{16'hFFFF, 24'hFFFFFF, 1'b0, 1},
      '{16'h0000, 24'h000000, 1'b1, 1},
      '{16'h1234, 24'h000000, 1'b0, -1},
      '{16'h1234, 24'h000000, 1'b0, -1},
      '{16'h1234, 24'h000000, 1'b1, -1},
      '{16'hAAAA, 24'h000005, 1'b0, -1},
      '{16'h5555, 24'h000005, 1'b0, -1},
      '{16'h00FF, 24'h000005, 1'b0, -1},
      '{16'hFF00, 24'h000005, 1'b1, -1},
      '{16'h0001, 24'h000001, 1'b0, -1},
      '{16'h0002, 24'h000002, 1'b0, -1},
      '{16'h0003, 24'h000004, 1'b0, -1},
      '{16'h0004, 24'h000008, 1'b0, -1},
      '{16'h0005, 24'h800000, 1'b0, -1},
      '{16'h0006, 24'h7FFFFF, 1'b1, -1},
      '{16'h8000, 24'hFFFFFF, 1'b0, -1},
      '{16'h7FFF, 24'hFFFFFF, 1'b0, -1},
      '{16'hC3C3, 24'hFFFFFF, 1'b1, -1}
   };

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      recv_hold   = 1'b0;
      held_count  = 0;
      send_idle_pct = 18;
      recv_idle_pct = 48;
      for (int i = 0; i < NODE_MAX; i++)
         live[i] = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_symbol(directed[i].symbol, directed[i].weight, directed[i].last,
                     directed[i].check_len);
      drain_codes();

      // Store full: 70 symbols, of which only the first 64 are held, with
      // weights doubling over the first 24 and the rest at the maximum weight.
      for (int i = 0; i < 70; i++)
         send_symbol(SYMBOL_W'(i), (i < 24) ? IN_WEIGHT_W'(1) << i : 24'hFFFFFF, i == 69);
      drain_codes();

      // Random blocks over the three idling phases, at least 46 symbols per phase.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 48 : 0;
         recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 18 : 0;
         for (int done = 0; done < 46;) begin
            int n;
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            // Long receiver hold-off while two blocks are sent behind it.
            if (phase == 2 && done == 0) begin
               recv_hold = 1'b1;
               fork
                  begin
                     repeat (2000) @(posedge clock);
                     recv_hold = 1'b0;
                  end
               join_none
               send_random_block(6);
               send_random_block(6);
               done += 12;
            end
            send_random_block(n);
            done += n;
         end
      end
      drain_codes();
      repeat (50) @(posedge clock);

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
